FILE: rtl/core/rhl_pkg.sv
// Shared types, constants and field layout for the recency history list.
`default_nettype none
package rhl_pkg;

  localparam int unsigned DEPTH_DEFAULT    = 128;
  localparam int unsigned ID_WIDTH_DEFAULT = 16;

  // Field widths on the stream and configuration ports
  localparam int unsigned OP_W   = 2;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CAP_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned IN_FIELDS_W   = WORD_W + POS_W;
  localparam int unsigned OUT_FIELDS_W  = 1 + POS_W + 1 + WORD_W + 1 + WORD_W + CNT_W;
  localparam int unsigned OUT_TDATA_W   = 56;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_DRAIN,
    S_FRONT,
    S_READ,
    S_RCAP,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic resolve;
    logic shift;
    logic drain;
    logic front;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic rd_in_range;
    logic scan_hit;
    logic scan_end;
    logic res_shift;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/rhl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module rhl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/rhl_ctrl.sv
// Sequencer for touch, clear, read and no-op operations on the history list.
`default_nettype none
module rhl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire rhl_pkg::sts_t sts_i,
  output rhl_pkg::cmd_t      cmd_o
);

  rhl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      rhl_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rhl_pkg::S_DECODE;
        end
      end
      rhl_pkg::S_DECODE: begin
        unique case (sts_i.op)
          rhl_pkg::OP_TOUCH: begin
            if (sts_i.count_zero) begin
              cmd_o.resolve = 1'b1;
              state_d       = rhl_pkg::S_FRONT;
            end else begin
              state_d = rhl_pkg::S_SCAN;
            end
          end
          rhl_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = rhl_pkg::S_DONE;
          end
          rhl_pkg::OP_READ: begin
            state_d = sts_i.rd_in_range ? rhl_pkg::S_READ : rhl_pkg::S_DONE;
          end
          rhl_pkg::OP_NOP: begin
            state_d = rhl_pkg::S_DONE;
          end
          default: state_d = rhl_pkg::S_DONE;
        endcase
      end
      rhl_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_end) begin
          cmd_o.resolve = 1'b1;
          state_d       = sts_i.res_shift ? rhl_pkg::S_SHIFT : rhl_pkg::S_FRONT;
        end
      end
      rhl_pkg::S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_last) begin
          state_d = rhl_pkg::S_DRAIN;
        end
      end
      rhl_pkg::S_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = rhl_pkg::S_FRONT;
      end
      rhl_pkg::S_FRONT: begin
        cmd_o.front = 1'b1;
        state_d     = rhl_pkg::S_DONE;
      end
      rhl_pkg::S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = rhl_pkg::S_RCAP;
      end
      rhl_pkg::S_RCAP: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = rhl_pkg::S_DONE;
      end
      rhl_pkg::S_DONE: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rhl_pkg::S_IDLE;
        end
      end
      default: state_d = rhl_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/rhl_dp.sv
// Datapath: entry RAM, scan and shift pointers, count, result and output registers.
`default_nettype none
module rhl_dp #(
  parameter int unsigned DEPTH    = rhl_pkg::DEPTH_DEFAULT,
  parameter int unsigned ID_WIDTH = rhl_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rhl_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  wire logic [rhl_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  wire logic [rhl_pkg::OP_W-1:0]           s_tuser_i,
  input  wire rhl_pkg::cmd_t                      cmd_i,
  output rhl_pkg::sts_t                           sts_o,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic      [rhl_pkg::OUT_TDATA_W-1:0]    m_tdata_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CAPCW = (CW > rhl_pkg::CAP_W) ? CW : rhl_pkg::CAP_W;
  localparam int unsigned POSCW = (CW > rhl_pkg::POS_W) ? CW : rhl_pkg::POS_W;
  localparam logic [CAPCW-1:0] DepthCap = CAPCW'(DEPTH);

  rhl_pkg::op_e                  op_q;
  logic [ID_WIDTH-1:0]           id_q;
  logic [rhl_pkg::POS_W-1:0]     pos_q;
  logic [CW-1:0]                 count_q;
  logic [rhl_pkg::CAP_W-1:0]     cap_q;
  logic [CW-1:0]                 rd_ptr_q;
  logic                          cmp_v_q;
  logic [AW-1:0]                 cmp_ptr_q;
  logic [AW-1:0]                 sh_ptr_q;
  logic                          wr_pend_q;
  logic [AW-1:0]                 wr_addr_q;
  logic                          res_hit_q;
  logic [rhl_pkg::POS_W-1:0]     res_hpos_q;
  logic                          res_ev_q;
  logic [rhl_pkg::WORD_W-1:0]    res_evid_q;
  logic                          res_rv_q;
  logic [rhl_pkg::WORD_W-1:0]    res_rid_q;
  logic                          m_valid_q;
  logic [rhl_pkg::OUT_TDATA_W-1:0] m_data_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ID_WIDTH-1:0]   ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ID_WIDTH-1:0]   ram_rdata;

  logic [rhl_pkg::WORD_W-1:0] in_word;
  logic [rhl_pkg::POS_W-1:0]  in_pos;
  logic                       scan_ok;
  logic                       scan_hit;
  logic                       scan_end;
  logic [CAPCW-1:0]           eff_cap;
  logic                       full;
  logic [CW-1:0]              res_len;

  assign in_word = s_tdata_i[rhl_pkg::WORD_W-1:0];
  assign in_pos  = s_tdata_i[rhl_pkg::WORD_W +: rhl_pkg::POS_W];

  assign scan_ok  = rd_ptr_q < count_q;
  assign scan_hit = cmp_v_q && (ram_rdata == id_q);
  assign scan_end = cmp_v_q && ((CW'(cmp_ptr_q) + CW'(1)) == count_q);

  // capacity zero acts as one, anything above the RAM depth as the depth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CAPCW'(1);
    end else if (CAPCW'(cap_q) > DepthCap) begin
      eff_cap = DepthCap;
    end else begin
      eff_cap = CAPCW'(cap_q);
    end
  end

  assign full = CAPCW'(count_q) >= eff_cap;

  // number of entries that slide down by one before the front write
  always_comb begin
    if (scan_hit) begin
      res_len = CW'(cmp_ptr_q);
    end else if (full) begin
      res_len = count_q - CW'(1);
    end else begin
      res_len = count_q;
    end
  end

  always_comb begin
    ram_we    = (wr_pend_q && (cmd_i.shift || cmd_i.drain)) || cmd_i.front;
    ram_waddr = cmd_i.front ? '0 : wr_addr_q;
    ram_wdata = cmd_i.front ? id_q : ram_rdata;
    ram_re    = (cmd_i.scan && scan_ok) || cmd_i.shift || cmd_i.rd_issue;
    if (cmd_i.shift) begin
      ram_raddr = sh_ptr_q;
    end else if (cmd_i.rd_issue) begin
      ram_raddr = AW'(pos_q);
    end else begin
      ram_raddr = AW'(rd_ptr_q);
    end
  end

  rhl_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cap_q     <= rhl_pkg::CAP_RESET;
      cmp_v_q   <= 1'b0;
      wr_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cmp_v_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_v_q <= scan_ok;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.resolve && !scan_hit && !full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.resolve || cmd_i.drain) begin
        wr_pend_q <= 1'b0;
      end else if (cmd_i.shift) begin
        wr_pend_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= rhl_pkg::op_e'(s_tuser_i);
      id_q       <= ID_WIDTH'(in_word);
      pos_q      <= in_pos;
      rd_ptr_q   <= '0;
      res_hit_q  <= 1'b0;
      res_hpos_q <= '0;
      res_ev_q   <= 1'b0;
      res_evid_q <= '0;
      res_rv_q   <= 1'b0;
      res_rid_q  <= '0;
    end
    if (cmd_i.scan) begin
      cmp_ptr_q <= AW'(rd_ptr_q);
      if (scan_ok) begin
        rd_ptr_q <= rd_ptr_q + CW'(1);
      end
    end
    if (cmd_i.resolve) begin
      sh_ptr_q <= AW'(res_len - CW'(1));
      if (scan_hit) begin
        res_hit_q  <= 1'b1;
        res_hpos_q <= rhl_pkg::POS_W'(cmp_ptr_q);
      end else if (full) begin
        res_ev_q   <= 1'b1;
        res_evid_q <= rhl_pkg::WORD_W'(ram_rdata);
      end
    end
    if (cmd_i.shift) begin
      sh_ptr_q  <= sh_ptr_q - AW'(1);
      wr_addr_q <= sh_ptr_q + AW'(1);
    end
    if (cmd_i.rd_capture) begin
      res_rv_q  <= 1'b1;
      res_rid_q <= rhl_pkg::WORD_W'(ram_rdata);
    end
    if (cmd_i.out_load) begin
      m_data_q <= {{rhl_pkg::OUT_PAD_W{1'b0}}, rhl_pkg::CNT_W'(count_q), res_rid_q, res_rv_q,
                   res_evid_q, res_ev_q, res_hpos_q, res_hit_q};
    end
  end

  assign sts_o.op          = op_q;
  assign sts_o.count_zero  = count_q == '0;
  assign sts_o.rd_in_range = POSCW'(pos_q) < POSCW'(count_q);
  assign sts_o.scan_hit    = scan_hit;
  assign sts_o.scan_end    = scan_end;
  assign sts_o.res_shift   = res_len != '0;
  assign sts_o.shift_last  = sh_ptr_q == '0;
  assign sts_o.out_free    = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/recency_history_list_top.sv
// Touch scans up to the matched position or the entry count, one compare per cycle on the entry
//   RAM read port, then shifts the entries with one move per cycle and writes the front entry.
// Read fetches the entry only in range; clear and unused opcodes go to the result; one beat in work.
// A result waits in the output register while the next beat is accepted.
// Reset clears the count, sets capacity to 100; the entry RAM is not cleared.
// Capacity writes take effect at once and belong between beats.
`default_nettype none
module recency_history_list_top #(
  parameter int unsigned DEPTH    = rhl_pkg::DEPTH_DEFAULT,
  parameter int unsigned ID_WIDTH = rhl_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rhl_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // word_id[15:0], position[22:16], zero pad
  input  wire logic [rhl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  wire logic [rhl_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // hit[0], hit_position[7:1], evicted[8], evicted_id[24:9], read_valid[25],
  // read_id[41:26], count[49:42], zero pad
  output logic      [rhl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  rhl_pkg::cmd_t cmd;
  rhl_pkg::sts_t sts;

  rhl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rhl_dp #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

  a_one_ram_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.scan, cmd.shift, cmd.drain, cmd.front, cmd.rd_issue, cmd.rd_capture,
              cmd.clear, cmd.out_load}))
    else $error("more than one datapath operation in a cycle");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while still full");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while one is in work");

  a_front_after_noshift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.resolve && !sts.res_shift) |=> cmd.front)
    else $error("front write missing after a touch with nothing to move");

endmodule
`default_nettype wire
